// ===== rtl/sisf_pkg.sv =====
`default_nettype none

package sisf_pkg;

  // Largest magnitude that fits the five-digit display
  localparam int unsigned MAX_SHOWN = 99999;

  localparam int unsigned NUM_BCD  = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned NUM_SHOW = 5;   // digits on the display

  // Seven-segment codes, bit0 = a through bit6 = g
  localparam logic [6:0] SEG_0 = 7'h3F;
  localparam logic [6:0] SEG_1 = 7'h06;
  localparam logic [6:0] SEG_2 = 7'h5B;
  localparam logic [6:0] SEG_3 = 7'h4F;
  localparam logic [6:0] SEG_4 = 7'h66;
  localparam logic [6:0] SEG_5 = 7'h6D;
  localparam logic [6:0] SEG_6 = 7'h7D;
  localparam logic [6:0] SEG_7 = 7'h07;
  localparam logic [6:0] SEG_8 = 7'h7F;
  localparam logic [6:0] SEG_9 = 7'h6F;

  // Truncating quotient and remainder of a division by three
  typedef struct packed {
    logic signed [4:0] q;
    logic signed [2:0] r;
  } div3_t;

  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = SEG_0;
      4'd1:    s = SEG_1;
      4'd2:    s = SEG_2;
      4'd3:    s = SEG_3;
      4'd4:    s = SEG_4;
      4'd5:    s = SEG_5;
      4'd6:    s = SEG_6;
      4'd7:    s = SEG_7;
      4'd8:    s = SEG_8;
      4'd9:    s = SEG_9;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Divide a small signed value (-47..47) by three, rounding toward zero.
  // The magnitude is scaled by 43/128, exact for magnitudes below 128.
  function automatic div3_t div3(input logic signed [6:0] p);
    logic [5:0]  a;
    logic [11:0] prod;
    logic [3:0]  qa;
    logic [5:0]  ra;
    div3_t       res;
    a    = p[6] ? 6'(-p) : 6'(p);
    prod = 12'(a) * 12'd43;
    qa   = 4'(prod >> 7);
    ra   = a - 6'(6'(qa) * 6'd3);
    res.q = p[6] ? 5'(-{1'b0, qa}) : {1'b0, qa};
    res.r = p[6] ? 3'(-{1'b0, ra[1:0]}) : {1'b0, ra[1:0]};
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/si_prefix_seven_segment_formatter_core.sv =====
`default_nettype none

// Formats a signed 32-bit reading with a decimal exponent for a five-digit
// seven-segment display: sign, five digit codes, decimal point and an SI
// prefix annunciator from nano to mega. The magnitude is truncated to five
// significant digits, raising the exponent by one per dropped digit. An
// item is loaded at the accepting edge, then passes the bit-serial
// binary-to-BCD shifter over all 32 magnitude bits (one magnitude bit per
// cycle), a state that selects the shown digits and one that places the
// point and prefix and writes the result to the output register. The next
// request is taken only after the result is written, and a result is
// written only once the last one has been taken, so a waiting result holds
// off new requests; the block takes no new item until the last is through.
// early_point_enable resets to 1 and must only be written while idle.
module si_prefix_seven_segment_formatter_core
  import sisf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // early_point_enable
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,       // [31:0] reading, [37:32] exponent
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0] m_tdata  // [0] negative, [1] prefix_nano, [2] prefix_micro,
                               // [3] prefix_milli, [4] prefix_kilo, [5] prefix_mega,
                               // [12:6] digit0_segments, [19:13] digit1_segments,
                               // [26:20] digit2_segments, [33:27] digit3_segments,
                               // [40:34] digit4_segments, [44:41] point_flags
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  logic [4:0]        cnt;
  logic [31:0]       bin;
  logic [39:0]       bcd;
  logic [39:0]       bcd_adj;
  logic              neg;
  logic signed [5:0] expo;
  logic [19:0]       sel;
  logic [2:0]        ndig;
  logic signed [6:0] p_r;
  logic              early_point_enable;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      early_point_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      early_point_enable <= cfg_wr_data;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_BCD; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Find the leading digit and pick the five digits to show
  logic [3:0]  dig [NUM_BCD];
  logic [3:0]  lead;
  logic        any_nz;
  logic [2:0]  drop;
  logic [19:0] sel_next;
  logic [2:0]  ndig_next;
  logic [3:0]  didx;

  always_comb begin
    lead   = 4'd0;
    any_nz = 1'b0;
    for (int i = 0; i < NUM_BCD; i++) begin
      dig[i] = bcd[4*i +: 4];
      if (bcd[4*i +: 4] != 4'd0) begin
        lead   = 4'(i);
        any_nz = 1'b1;
      end
    end
    drop = (lead > 4'd4) ? 3'(lead - 4'd4) : 3'd0;
    for (int i = 0; i < NUM_SHOW; i++) begin
      didx = 4'(drop) + 4'(i);
      sel_next[4*i +: 4] = dig[didx];
    end
    if (!any_nz) begin
      ndig_next = 3'd0;
    end else if (lead > 4'd4) begin
      ndig_next = 3'd5;
    end else begin
      ndig_next = 3'(lead + 4'd1);
    end
  end

  // Place the point and the prefix group
  div3_t             dv;
  logic signed [5:0] grp;
  logic [2:0]        pt;
  logic              blank;
  logic [3:0]        pflags;
  logic [47:0]       result;

  always_comb begin
    dv    = div3(p_r);
    grp   = {dv.q[4], dv.q};
    pt    = 3'd0;
    blank = 1'b0;
    if (p_r > 7'sd0) begin
      grp = grp + 6'sd1;
      pt  = 3'd3 - {1'b0, dv.r[1:0]};
    end else if (p_r < 7'sd0) begin
      pt = 3'(-dv.r);
      if (grp < -6'sd3) begin
        if (pt < 3'd2 && grp == -6'sd4) begin
          grp = grp + 6'sd1;
          pt  = pt + 3'd3;
        end else begin
          grp   = -6'sd3;
          blank = 1'b1;
          pt    = 3'd0;
        end
      end
    end
    if (early_point_enable && ndig > 3'd2 && pt < 3'd2) begin
      grp = grp + 6'sd1;
      pt  = pt + 3'd3;
    end
    pflags = (pt >= 3'd1 && pt <= 3'd4) ? 4'(4'd1 << (pt - 3'd1)) : 4'd0;

    result       = '0;
    result[0]    = neg;
    result[1]    = (grp == -6'sd3);
    result[2]    = (grp == -6'sd2);
    result[3]    = (grp == -6'sd1);
    result[4]    = (grp == 6'sd1);
    result[5]    = (grp == 6'sd2);
    for (int i = 0; i < NUM_SHOW; i++) begin
      result[6 + 7*i +: 7] = seg_code(blank ? 4'd0 : sel[4*i +: 4]);
    end
    result[44:41] = pflags;
  end

  // Sequencer: load, shift 32 bits, select digits, format
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CONV;
            cnt   <= '0;
          end
        end
        ST_CONV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // raise valid on a new result, drop it once taken
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          neg  <= s_tdata[31];
          bin  <= s_tdata[31] ? 32'(-s_tdata[31:0]) : s_tdata[31:0];
          expo <= $signed(s_tdata[37:32]);
          bcd  <= '0;
        end
      end
      ST_CONV: begin
        bcd <= {bcd_adj[38:0], bin[31]};
        bin <= {bin[30:0], 1'b0};
      end
      ST_NORM: begin
        sel  <= sel_next;
        ndig <= ndig_next;
        p_r  <= 7'({expo[5], expo}) + 7'(drop);
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= result;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
